// ----- hdl/fvc_pkg.sv -----
`default_nettype none

package fvc_pkg;

	localparam int VERTEX_W       = 16;
	localparam int COUNT_W        = 32;
	localparam int CFG_W          = 5;
	localparam int RING_DEPTH_DEF = 16;

	localparam logic [CFG_W-1:0]   CACHE_ENTRIES_RST = CFG_W'(10);
	localparam logic [COUNT_W-1:0] COUNT_MAX         = {COUNT_W{1'b1}};

	// per-item control from the core to the cache window
	typedef struct packed {
		logic step;
		logic last;
	} fvc_upd_t;

endpackage

`default_nettype wire

// ----- hdl/fvc_ifs.sv -----
`default_nettype none

interface fvc_vtx_if import fvc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VERTEX_W-1:0] vertex_index;
	logic                last_index;

	modport source (output valid, output vertex_index, output last_index, input ready);
	modport sink   (input valid, input vertex_index, input last_index, output ready);
endinterface

interface fvc_res_if import fvc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [COUNT_W-1:0] hit_count;
	logic               sequence_end;

	modport source (output valid, output hit, output hit_count, output sequence_end,
		input ready);
	modport sink   (input valid, input hit, input hit_count, input sequence_end,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/fvc_window.sv -----
`default_nettype none

module fvc_window import fvc_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fvc_upd_t                          upd,
	input  wire logic [VERTEX_W-1:0]               vertex,
	input  wire logic [$clog2(RING_DEPTH+1)-1:0]   win,
	output logic                                   hit
);

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH+1);
	localparam int POS_W  = FILL_W + 1;

	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);
	localparam logic [POS_W-1:0]  DEPTH_P = POS_W'(RING_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(RING_DEPTH - 1);

	logic [VERTEX_W-1:0] ring_q [RING_DEPTH];
	logic [IDX_W-1:0]    oldest_q;
	logic [FILL_W-1:0]   fill_q;

	logic [FILL_W-1:0]     eff;
	logic [FILL_W-1:0]     first;
	logic [RING_DEPTH-1:0] match;
	logic [POS_W-1:0]      wpos_raw;
	logic [POS_W-1:0]      wpos;

	assign eff   = (fill_q < win) ? fill_q : win;
	assign first = fill_q - eff;

	// slot k sits at age offset (k - oldest) mod depth; only the newest
	// eff entries take part in the compare
	for (genvar k = 0; k < RING_DEPTH; k++) begin : g_slot
		logic [POS_W-1:0] offs;
		logic             in_win;

		always_comb begin
			if (POS_W'(k) >= POS_W'(oldest_q)) begin
				offs = POS_W'(k) - POS_W'(oldest_q);
			end else begin
				offs = POS_W'(k) + DEPTH_P - POS_W'(oldest_q);
			end
		end

		assign in_win   = (offs >= POS_W'(first)) && (offs < POS_W'(fill_q));
		assign match[k] = in_win && (ring_q[k] == vertex);
	end

	assign hit = |match;

	assign wpos_raw = POS_W'(oldest_q) + POS_W'(fill_q);
	assign wpos     = (wpos_raw >= DEPTH_P) ? (wpos_raw - DEPTH_P) : wpos_raw;

	always_ff @(posedge clk) begin
		if (upd.step) begin
			ring_q[wpos[IDX_W-1:0]] <= vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (upd.step) begin
			if (upd.last) begin
				oldest_q <= '0;
				fill_q   <= '0;
			end else if (fill_q < win) begin
				fill_q <= fill_q + FILL_W'(1);
			end else begin
				oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + IDX_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill level above ring depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q <= LAST_SLOT)
		else $error("oldest slot outside ring");

	a_seq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		upd.step && upd.last |=> fill_q == '0 && oldest_q == '0)
		else $error("window not cleared at sequence end");
`endif

endmodule

`default_nettype wire

// ----- hdl/fifo_vertex_cache_hit_counter_core.sv -----
`default_nettype none

// FIFO vertex cache hit counter. Takes one vertex index per cycle, back to back, while
// results are accepted. The index goes into an input register, and its result is
// loaded into the result register once that register is free or drained. The result
// says whether the index matched one of the newest cache_entries indices of the current
// sequence, and gives the saturating hit count so far. Every index is inserted afterwards;
// the item flagged last_index closes the sequence and clears window and count.
// Throughput is one item per cycle while results are accepted, set by the
// combinational parallel compare of the index against every ring slot.
// cache_entries (0 acts as 1, values above RING_DEPTH act as RING_DEPTH) may only
// be written while the block is idle.
// No clearing pass is needed after reset.
module fifo_vertex_cache_hit_counter_core import fvc_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	fvc_vtx_if.sink               vtx,
	fvc_res_if.source             res
);

	localparam int FILL_W = $clog2(RING_DEPTH+1);
	localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

	logic [CFG_W-1:0] cache_entries_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [FILL_W-1:0] win;

	logic                s1_valid;
	logic [VERTEX_W-1:0] vertex_s1;
	logic                last_s1;

	logic               out_valid_q;
	logic               hit_q;
	logic [COUNT_W-1:0] count_q;
	logic               seq_end_q;
	logic [COUNT_W-1:0] running_hits_q;

	logic               adv;
	logic               win_hit;
	logic [COUNT_W-1:0] next_count;
	fvc_upd_t           upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_entries_q <= CACHE_ENTRIES_RST;
		end else if (cfg_we) begin
			cache_entries_q <= cfg_wdata;
		end
	end

	assign cfg_ext = CMP_W'(cache_entries_q);

	always_comb begin
		if (cfg_ext == '0) begin
			win = FILL_W'(1);
		end else if (cfg_ext > CMP_W'(RING_DEPTH)) begin
			win = FILL_W'(RING_DEPTH);
		end else begin
			win = cfg_ext[FILL_W-1:0];
		end
	end

	// s1 item moves into the output register when that register is free or drained
	assign adv       = s1_valid && (!out_valid_q || res.ready);
	assign vtx.ready = !s1_valid || adv;

	assign upd.step = adv;
	assign upd.last = last_s1;

	fvc_window #(
		.RING_DEPTH(RING_DEPTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.vertex (vertex_s1),
		.win    (win),
		.hit    (win_hit)
	);

	assign next_count = (win_hit && running_hits_q != COUNT_MAX) ?
		running_hits_q + COUNT_W'(1) : running_hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (vtx.ready) begin
			s1_valid <= vtx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vtx.valid && vtx.ready) begin
			vertex_s1 <= vtx.vertex_index;
			last_s1   <= vtx.last_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			running_hits_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q    <= 1'b1;
				running_hits_q <= last_s1 ? '0 : next_count;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q     <= win_hit;
			count_q   <= next_count;
			seq_end_q <= last_s1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.hit          = hit_q;
	assign res.hit_count    = count_q;
	assign res.sequence_end = seq_end_q;

`ifndef SYNTHESIS
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> running_hits_q == '0)
		else $error("hit count not cleared at sequence end");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> count_q != '0)
		else $error("hit reported with zero count");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && !res.ready |-> !vtx.ready)
		else $error("input taken while both stages are full");

	a_adv_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item lost");
`endif

endmodule

`default_nettype wire
